### rtl/mscb_pkg.sv
`default_nettype none
package mscb_pkg;

   localparam int WORD_MAX = 64;
   localparam int IDX_W = 6;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_WORD_BITS  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_BIT = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPLIT_T    = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPLIT_M    = 8'd3;

   typedef struct packed {
      logic [63:0] word_z1;
      logic [63:0] word_z2;
      logic [63:0] word_x3;
      logic [63:0] key_one;
      logic [63:0] key_two;
   } req_type;

   typedef struct packed {
      logic       borrow_out;
      logic       split_valid;
      logic       window_equal;
      logic [5:0] first_diff_offset;
      logic       settings_ok;
   } rsp_type;

   typedef struct packed {
      logic                ok;
      logic [IDX_W-1:0]    bit_idx;
      logic [IDX_W-1:0]    lo;
      logic [WORD_MAX-1:0] win_mask;
      logic [WORD_MAX-1:0] seg_mask;
   } cfg_type;

   typedef struct packed {
      logic                borrow;
      logic [WORD_MAX-1:0] diff_iso;
      logic [WORD_MAX-1:0] yz1;
   } chain_type;

   function automatic logic [WORD_MAX-1:0] mask_below(input logic [6:0] k);
      logic [WORD_MAX-1:0] m;
      if (k >= 7'(WORD_MAX)) begin
         m = '1;
      end else begin
         m = (WORD_MAX'(1) << k) - WORD_MAX'(1);
      end
      return m;
   endfunction

endpackage
`default_nettype wire

### rtl/mscb_csr.sv
`default_nettype none
module mscb_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [mscb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [mscb_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output mscb_pkg::cfg_type                       cfg
);

   logic [6:0] word_bits_ff;
   logic [5:0] target_bit_ff;
   logic [5:0] split_t_ff;
   logic [5:0] split_m_ff;

   logic [6:0] n_eff;
   logic [6:0] sum_tm;
   logic [6:0] i_eff;
   logic [6:0] lo_bit;
   logic [6:0] mid_bit;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         word_bits_ff  <= 7'd32;
         target_bit_ff <= 6'd16;
         split_t_ff    <= 6'd1;
         split_m_ff    <= 6'd2;
      end else if (csr_valid) begin
         case (csr_index)
            mscb_pkg::CSR_WORD_BITS:  word_bits_ff  <= csr_wdata[6:0];
            mscb_pkg::CSR_TARGET_BIT: target_bit_ff <= csr_wdata[5:0];
            mscb_pkg::CSR_SPLIT_T:    split_t_ff    <= csr_wdata[5:0];
            mscb_pkg::CSR_SPLIT_M:    split_m_ff    <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      n_eff   = (word_bits_ff > 7'(mscb_pkg::WORD_MAX)) ? 7'(mscb_pkg::WORD_MAX)
                                                        : word_bits_ff;
      sum_tm  = {1'b0, split_t_ff} + {1'b0, split_m_ff};
      i_eff   = ({1'b0, target_bit_ff} <= sum_tm) ? sum_tm + 7'd1 : {1'b0, target_bit_ff};
      lo_bit  = i_eff - sum_tm;
      mid_bit = i_eff - {1'b0, split_m_ff};
      cfg.ok       = i_eff < n_eff;
      cfg.bit_idx  = i_eff[5:0];
      cfg.lo       = lo_bit[5:0];
      cfg.win_mask = mscb_pkg::mask_below(i_eff) & ~mscb_pkg::mask_below(lo_bit);
      cfg.seg_mask = mscb_pkg::mask_below(i_eff) & ~mscb_pkg::mask_below(mid_bit);
   end

endmodule
`default_nettype wire

### rtl/mscb_chain.sv
`default_nettype none
module mscb_chain (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire mscb_pkg::req_type  in_word,
   input  wire mscb_pkg::cfg_type  cfg,
   output logic                    out_valid,
   output mscb_pkg::chain_type     out_word
);

   logic [63:0] y2;
   logic [63:0] x2_in;
   logic [63:0] dw_in;

   logic        v1_ff;
   logic [63:0] x2_ff;
   logic [63:0] dw_ff;
   logic [63:0] z1_ff;
   logic [63:0] k1_ff;

   logic [63:0] y1;
   logic [63:0] x1;
   logic [63:0] b1;
   mscb_pkg::chain_type out_in;

   logic                v2_ff;
   mscb_pkg::chain_type out_ff;

   always_comb begin
      y2    = in_word.word_x3 ^ in_word.key_two;
      x2_in = in_word.word_z2 - y2;
      dw_in = (y2 ^ in_word.word_z2) & cfg.win_mask;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
      x2_ff <= x2_in;
      dw_ff <= dw_in;
      z1_ff <= in_word.word_z1;
      k1_ff <= in_word.key_one;
   end

   always_comb begin
      y1              = x2_ff ^ k1_ff;
      x1              = z1_ff - y1;
      b1              = x1 ^ y1 ^ z1_ff;
      out_in.borrow   = b1[cfg.bit_idx];
      out_in.diff_iso = dw_ff & (~dw_ff + 64'd1);
      out_in.yz1      = y1 ^ z1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      out_ff <= out_in;
   end

   assign out_valid = v2_ff;
   assign out_word  = out_ff;

endmodule
`default_nettype wire

### rtl/mscb_scan.sv
`default_nettype none
module mscb_scan (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire mscb_pkg::chain_type  in_word,
   input  wire mscb_pkg::cfg_type    cfg,
   output logic                      rsp_valid,
   output mscb_pkg::rsp_type         rsp_data
);

   logic [63:0]       below;
   logic [63:0]       hits;
   logic [5:0]        enc;
   logic              equal;
   mscb_pkg::rsp_type rsp_in;

   logic              rsp_valid_ff;
   mscb_pkg::rsp_type rsp_ff;

   always_comb begin
      below = in_word.diff_iso | (in_word.diff_iso - 64'd1);
      hits  = in_word.yz1 & ~below & cfg.seg_mask;
      equal = (in_word.diff_iso == 64'd0);
      enc   = 6'd0;
      for (int k = 0; k < 64; k++) begin
         if (in_word.diff_iso[k]) begin
            enc = enc | 6'(k);
         end
      end
      rsp_in = '0;
      if (cfg.ok) begin
         rsp_in.settings_ok       = 1'b1;
         rsp_in.borrow_out        = in_word.borrow;
         rsp_in.window_equal      = equal;
         rsp_in.split_valid       = |hits;
         rsp_in.first_diff_offset = equal ? 6'd0 : enc - cfg.lo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= in_valid;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

### rtl/modsub_chain_borrow_split_check.sv
// Throughput: one word per cycle; busy stays low, so start may be held high indefinitely.
// The pipeline is input register, first subtraction, second subtraction, result register.
// The receiver cannot stall; every result is shown for exactly one cycle.
// Synchronous reset clears the valid bits and loads the register defaults.
`default_nettype none
module modsub_chain_borrow_split_check (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire mscb_pkg::req_type                  req_data,
   output logic                                    rsp_valid,
   output mscb_pkg::rsp_type                       rsp_data,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [mscb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [mscb_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   mscb_pkg::cfg_type   cfg;
   logic                req_valid_ff;
   mscb_pkg::req_type   req_ff;
   logic                chain_valid;
   mscb_pkg::chain_type chain_word;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
      req_ff <= req_data;
   end

   mscb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mscb_chain u_chain (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid_ff),
      .in_word   (req_ff),
      .cfg       (cfg),
      .out_valid (chain_valid),
      .out_word  (chain_word)
   );

   mscb_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_valid),
      .in_word   (chain_word),
      .cfg       (cfg),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 4))
      else $error("result without a word accepted four cycles earlier");

   a_equal_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.window_equal |-> rsp_data.first_diff_offset == 6'd0)
      else $error("nonzero offset on an equal window");

   a_valid_needs_diff: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.split_valid |-> !rsp_data.window_equal && rsp_data.settings_ok)
      else $error("split valid without a difference in the window");

   a_bad_settings: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.settings_ok |-> !rsp_data.borrow_out && !rsp_data.window_equal)
      else $error("result fields set under bad settings");
`endif

endmodule
`default_nettype wire
